// ===== hdl/psw_pkg.sv =====
// ----------------------------------------------------------------------------
// psw_pkg
// Types and field widths shared by the priority scheduler core.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int NUM_W   = 5;
  localparam int TIME_W  = 20;

  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  job_priority;
    logic               last_job;
  } job_t;

  typedef struct packed {
    logic [NUM_W-1:0]   job_number;
    logic [BURST_W-1:0] job_burst;
    logic [PRIO_W-1:0]  job_prio;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  average_wait;
    logic [TIME_W-1:0]  average_turnaround;
    logic               overflowed;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [NUM_W-1:0]   number;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SHIFT,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/priority_schedule_wait_times_core.sv =====
// ----------------------------------------------------------------------------
// priority_schedule_wait_times_core
// Non-preemptive priority scheduler: batch wait and turnaround times.
//
// Jobs arrive on the job channel (job_valid / job_stall) and are inserted
// into a sorted job table held in a one-port-read, one-port-write RAM.
// Insertion moves each entry of higher priority value up one place and
// then writes the new job into the freed place.
// The item marked last_job then starts the schedule: a sum pass over the
// table, a serial divide for both averages, and an emit pass that streams
// one result per cycle on the result channel while the receiver takes
// them. A stalled result holds in the output register; the emit pass waits
// until it is taken. job_stall stays high from an accepted item until its
// insertion, or the schedule it starts, is done.
// Jobs beyond MAX_JOBS are dropped and flagged as overflowed.
// Reset empties the batch; the table needs no clearing.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_core import psw_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_stall,
  input  job_t    job,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int AW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int EW  = BURST_W + CW;
  localparam int TW  = EW + CW;
  localparam int EXW = (EW > TIME_W) ? EW : TIME_W;
  localparam int QXW = (TW > TIME_W) ? TW : TIME_W;

  state_t state, state_next;

  logic [CW-1:0]      job_count;
  logic               drop_flag;
  logic [BURST_W-1:0] new_burst;
  logic [PRIO_W-1:0]  new_prio;
  logic               new_last;
  logic [AW-1:0]      pos;
  logic [CW-1:0]      rd_idx;
  logic               sum_vld;
  logic [EW-1:0]      elapsed;
  logic [TW-1:0]      total_wait;
  logic [AW-1:0]      emit_idx;

  entry_t        job_table [MAX_JOBS];
  entry_t        rdata;
  entry_t        wdata;
  entry_t        new_entry;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic          job_acc;
  logic          full;
  logic          pos_zero;
  logic          shift_go;
  logic          sum_done;
  logic          emit_end;
  logic          placed;
  logic          div_start;
  logic          emit_ld;
  logic [CW:0]   count_inc;

  logic          wait_busy;
  logic          turn_busy;
  logic [TW-1:0] wait_q;
  logic [TW-1:0] turn_q;
  logic [EW-1:0] turn;
  logic [EXW-1:0] elx;
  logic [EXW-1:0] tnx;
  logic [QXW-1:0] qwx;
  logic [QXW-1:0] qtx;

  assign job_stall = (state != ST_IDLE);
  assign job_acc   = job_valid && !job_stall;
  assign full      = (job_count == CW'(MAX_JOBS));
  assign pos_zero  = (pos == '0);
  assign shift_go  = (rdata.prio > new_prio);
  assign sum_done  = (rd_idx == job_count) && !sum_vld;
  assign emit_end  = (CW'(emit_idx) == job_count - CW'(1));
  assign count_inc = {1'b0, job_count} + (CW + 1)'(1);

  assign new_entry.burst  = new_burst;
  assign new_entry.prio   = new_prio;
  assign new_entry.number = NUM_W'(count_inc);

  assign turn = elapsed + EW'(rdata.burst);
  assign elx  = EXW'(elapsed);
  assign tnx  = EXW'(turn);
  assign qwx  = QXW'(wait_q);
  assign qtx  = QXW'(turn_q);

  always_ff @(posedge clk) begin
    if (we) begin
      job_table[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= job_table[raddr];
    end
  end

  psw_div #(.DW(TW), .VW(CW)) u_div_wait (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_wait),
    .divisor  (job_count),
    .busy     (wait_busy),
    .quotient (wait_q)
  );

  psw_div #(.DW(TW), .VW(CW)) u_div_turn (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_wait + TW'(elapsed)),
    .divisor  (job_count),
    .busy     (turn_busy),
    .quotient (turn_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_acc) begin
          if (!full) begin
            state_next = ST_INSERT;
          end else if (job.last_job) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_INSERT: begin
        if (pos_zero) begin
          state_next = new_last ? ST_SUM : ST_IDLE;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (shift_go) begin
          state_next = (pos == AW'(1)) ? ST_INSERT : ST_SHIFT;
        end else begin
          state_next = new_last ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!wait_busy && !turn_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ld && emit_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    re        = 1'b0;
    waddr     = pos;
    raddr     = '0;
    wdata     = new_entry;
    placed    = 1'b0;
    div_start = 1'b0;
    emit_ld   = 1'b0;
    case (state)
      ST_INSERT: begin
        if (pos_zero) begin
          we     = 1'b1;
          placed = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = pos - AW'(1);
        end
      end
      ST_SHIFT: begin
        we = 1'b1;
        if (shift_go) begin
          wdata = rdata;
          if (pos != AW'(1)) begin
            re    = 1'b1;
            raddr = pos - AW'(2);
          end
        end else begin
          placed = 1'b1;
        end
      end
      ST_SUM: begin
        if (rd_idx != job_count) begin
          re    = 1'b1;
          raddr = AW'(rd_idx);
        end
        div_start = sum_done;
      end
      ST_DIV: begin
        if (!wait_busy && !turn_busy) begin
          re = 1'b1;
        end
      end
      ST_EMIT: begin
        emit_ld = !result_valid || !result_stall;
        if (emit_ld && !emit_end) begin
          re    = 1'b1;
          raddr = emit_idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      job_count    <= '0;
      drop_flag    <= 1'b0;
      sum_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (job_acc && full) begin
        drop_flag <= 1'b1;
      end
      if (placed) begin
        job_count <= job_count + CW'(1);
      end
      sum_vld <= (state == ST_SUM) && re;
      if (emit_ld) begin
        result_valid <= 1'b1;
        if (emit_end) begin
          job_count <= '0;
          drop_flag <= 1'b0;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_acc) begin
      new_burst <= job.burst_time;
      new_prio  <= job.job_priority;
      new_last  <= job.last_job;
      pos       <= AW'(job_count);
    end else if (state == ST_SHIFT && shift_go) begin
      pos <= pos - AW'(1);
    end
    case (state)
      ST_SUM: begin
        if (re) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (sum_vld) begin
          total_wait <= total_wait + TW'(elapsed);
          elapsed    <= elapsed + EW'(rdata.burst);
        end
      end
      ST_DIV: begin
        elapsed  <= '0;
        emit_idx <= '0;
      end
      ST_EMIT: begin
        if (emit_ld) begin
          elapsed  <= turn;
          emit_idx <= emit_idx + AW'(1);
        end
      end
      default: begin
        rd_idx     <= '0;
        elapsed    <= '0;
        total_wait <= '0;
      end
    endcase
    if (emit_ld) begin
      result.job_number         <= rdata.number;
      result.job_burst          <= rdata.burst;
      result.job_prio           <= rdata.prio;
      result.wait_time          <= elx[TIME_W-1:0];
      result.turnaround_time    <= tnx[TIME_W-1:0];
      result.average_wait       <= qwx[TIME_W-1:0];
      result.average_turnaround <= qtx[TIME_W-1:0];
      result.overflowed         <= drop_flag;
      result.last_result        <= emit_end;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= CW'(MAX_JOBS))
    else $error("job count above capacity");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_INSERT || state == ST_SHIFT))
    else $error("table write outside insertion");

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("read and write to the same table entry");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (job_count != '0))
    else $error("emit pass with an empty table");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (wait_busy && turn_busy))
    else $error("divider did not start");
`endif

endmodule

// ===== hdl/psw_div.sv =====
// ----------------------------------------------------------------------------
// psw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psw_div #(
  parameter int DW = 26,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [DW-1:0]   quo;
  logic [VW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            fits;

  assign trial    = {rem, quo[DW-1]};
  assign diff     = trial - {1'b0, dsr};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNTW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
      cnt <= CNTW'(DW);
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
      cnt <= cnt - CNTW'(1);
    end
  end

endmodule
